// ===== rtl/e2c_pkg.sv =====
// Shared constants, tables and types for the epoch to calendar converter.
`default_nettype none

package e2c_pkg;

    localparam int unsigned EpochW = 32;
    localparam int unsigned TminW  = 27;  // total minutes, below 2^27
    localparam int unsigned ThrW   = 21;  // total hours
    localparam int unsigned TdayW  = 16;  // total days
    localparam int unsigned EraW   = 6;   // four-year eras, at most 34
    localparam int unsigned DoeW   = 11;  // day of era, 0..1460
    localparam int unsigned DoyW   = 9;   // day of year, 0..365

    // Reciprocal multipliers for the constant divisions.
    localparam logic [31:0] RECIP_60   = 32'h8888_8889;  // x/60 = (x*R) >> 37
    localparam int unsigned SHIFT_60   = 37;
    localparam logic [31:0] RECIP_24   = 32'hAAAA_AAAB;  // x/24 = (x*R) >> 36
    localparam int unsigned SHIFT_24   = 36;
    localparam logic [16:0] RECIP_1461 = 17'd91868;      // x/1461 = (x*R) >> 27
    localparam int unsigned SHIFT_1461 = 27;

    localparam logic [5:0]  SEC_PER_MIN   = 6'd60;
    localparam logic [5:0]  MIN_PER_HOUR  = 6'd60;
    localparam logic [4:0]  HOUR_PER_DAY  = 5'd24;
    localparam logic [10:0] ERA_DAYS      = 11'd1461;
    localparam logic [EpochW-1:0] LAST_VALID_EPOCH = 32'd3155759999;

    localparam logic [DoeW-1:0] YEAR1_BEGIN = 11'd366;
    localparam logic [DoeW-1:0] YEAR2_BEGIN = 11'd731;
    localparam logic [DoeW-1:0] YEAR3_BEGIN = 11'd1096;

    localparam logic [DoyW-1:0] MONTH_BEGIN_COMMON [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };
    localparam logic [DoyW-1:0] MONTH_BEGIN_LEAP [12] = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
        9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
    };

    typedef struct packed {
        logic            leap;
        logic [DoyW-1:0] doy;
    } e2c_doy_t;

    typedef struct packed {
        logic [3:0] month;
        logic [4:0] day;
    } e2c_md_t;

endpackage

`default_nettype wire

// ===== rtl/e2c_month_decode.sv =====
// Day-of-year to month and day-of-month decode against the month-start tables.
`default_nettype none

module e2c_month_decode
    import e2c_pkg::*;
(
    input  e2c_doy_t doy_in,
    output e2c_md_t  md_out
);

    logic [DoyW-1:0] base;
    logic [3:0]      month;

    // Independent compares; walking down leaves the first month whose start lies above doy.
    always_comb begin
        month = 4'd12;
        base  = doy_in.leap ? MONTH_BEGIN_LEAP[11] : MONTH_BEGIN_COMMON[11];
        for (int m = 11; m >= 1; m--) begin
            if (doy_in.leap) begin
                if (doy_in.doy < MONTH_BEGIN_LEAP[m]) begin
                    month = 4'(m);
                    base  = MONTH_BEGIN_LEAP[m-1];
                end
            end else begin
                if (doy_in.doy < MONTH_BEGIN_COMMON[m]) begin
                    month = 4'(m);
                    base  = MONTH_BEGIN_COMMON[m-1];
                end
            end
        end
    end

    assign md_out.month = month;
    assign md_out.day   = 5'(doy_in.doy - base + 9'd1);

endmodule

`default_nettype wire

// ===== rtl/epoch_to_calendar_datetime.sv =====
// Pipelined converter from seconds since 2000-01-01 to calendar date and time.
//
// Usage:
//   s_tdata[31:0] carries epoch_seconds. One word is taken when s_tvalid and
//   s_tready are both high.
//   m_tdata carries, from bit 0 up: year_offset[7:0], month_number[11:8],
//   day_of_month[16:12], hour_of_day[21:17], minute_of_hour[27:22],
//   second_of_minute[33:28], zero fill [39:34]. m_tuser[0] is
//   past_valid_range, set for dates after 2099-12-31 23:59:59.
//   One word per cycle is taken and delivered in steady state while m_tready
//   is high. The depth is set by the three reciprocal multipliers (divide by
//   60, 60, 24), the era multiplier (divide by 1461), the day-of-era
//   subtraction, the year compares and the month-table decode, one per stage.
//   Each stage holds while the stage after it is full and stalled, so a low
//   m_tready fills empty stages first and s_tready drops only when all seven
//   stages hold words. Nothing is dropped or repeated across a stall.
//   Reset (aresetn low, synchronous) empties the pipeline; m_tvalid is low
//   after reset and no word in flight is delivered.
`default_nettype none

module epoch_to_calendar_datetime
    import e2c_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // epoch_seconds[31:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // year, month, day, hour, minute, second, fill
    output logic [0:0]       m_tuser    // past_valid_range
);

    localparam int unsigned NStage = 7;

    logic [NStage-1:0] valid_reg;
    logic [NStage-1:0] en;

    // Stage enables: a stage loads when empty or when the next stage loads.
    always_comb begin
        en[NStage-1] = !valid_reg[NStage-1] || m_tready;
        for (int i = NStage - 2; i >= 0; i--) begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign s_tready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NStage; i++) begin
                if (en[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Stage 1: epoch / 60.
    logic [63:0]        prod1;
    logic [EpochW-1:0]  e1_reg;
    logic [TminW-1:0]   tmin1_reg;
    logic               pv1_reg;

    assign prod1 = {32'd0, s_tdata} * {32'd0, RECIP_60};

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            e1_reg    <= s_tdata;
            tmin1_reg <= prod1[SHIFT_60 +: TminW];
            pv1_reg   <= s_tdata > LAST_VALID_EPOCH;
        end
    end

    // Stage 2: second remainder, total minutes / 60.
    logic [58:0]       prod2;
    logic [5:0]        sec2_next;
    logic [5:0]        sec2_reg;
    logic [TminW-1:0]  tmin2_reg;
    logic [ThrW-1:0]   thr2_reg;
    logic              pv2_reg;

    assign prod2     = {32'd0, tmin1_reg} * {27'd0, RECIP_60};
    assign sec2_next = e1_reg[5:0] - 6'(tmin1_reg[5:0] * SEC_PER_MIN);

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            sec2_reg  <= sec2_next;
            tmin2_reg <= tmin1_reg;
            thr2_reg  <= prod2[SHIFT_60 +: ThrW];
            pv2_reg   <= pv1_reg;
        end
    end

    // Stage 3: minute remainder, total hours / 24.
    logic [52:0]      prod3;
    logic [5:0]       min3_next;
    logic [5:0]       sec3_reg;
    logic [5:0]       min3_reg;
    logic [ThrW-1:0]  thr3_reg;
    logic [TdayW-1:0] tday3_reg;
    logic             pv3_reg;

    assign prod3     = {32'd0, thr2_reg} * {21'd0, RECIP_24};
    assign min3_next = tmin2_reg[5:0] - 6'(thr2_reg[5:0] * MIN_PER_HOUR);

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            sec3_reg  <= sec2_reg;
            min3_reg  <= min3_next;
            thr3_reg  <= thr2_reg;
            tday3_reg <= prod3[SHIFT_24 +: TdayW];
            pv3_reg   <= pv2_reg;
        end
    end

    // Stage 4: hour remainder, total days / 1461.
    logic [32:0]      prod4;
    logic [4:0]       hr4_next;
    logic [5:0]       sec4_reg;
    logic [5:0]       min4_reg;
    logic [4:0]       hr4_reg;
    logic [TdayW-1:0] tday4_reg;
    logic [EraW-1:0]  era4_reg;
    logic             pv4_reg;

    assign prod4    = {17'd0, tday3_reg} * {16'd0, RECIP_1461};
    assign hr4_next = thr3_reg[4:0] - 5'(tday3_reg[4:0] * HOUR_PER_DAY);

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            sec4_reg  <= sec3_reg;
            min4_reg  <= min3_reg;
            hr4_reg   <= hr4_next;
            tday4_reg <= tday3_reg;
            era4_reg  <= prod4[SHIFT_1461 +: EraW];
            pv4_reg   <= pv3_reg;
        end
    end

    // Stage 5: day of era.
    logic [DoeW-1:0]  doe5_next;
    logic [5:0]       sec5_reg;
    logic [5:0]       min5_reg;
    logic [4:0]       hr5_reg;
    logic [DoeW-1:0]  doe5_reg;
    logic [EraW-1:0]  era5_reg;
    logic             pv5_reg;

    assign doe5_next = tday4_reg[DoeW-1:0] - DoeW'({5'd0, era4_reg} * ERA_DAYS);

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            sec5_reg <= sec4_reg;
            min5_reg <= min4_reg;
            hr5_reg  <= hr4_reg;
            doe5_reg <= doe5_next;
            era5_reg <= era4_reg;
            pv5_reg  <= pv4_reg;
        end
    end

    // Stage 6: year within era, day of year.
    logic [1:0]       yie6;
    logic [DoeW-1:0]  ybegin6;
    logic [5:0]       sec6_reg;
    logic [5:0]       min6_reg;
    logic [4:0]       hr6_reg;
    logic [7:0]       year6_reg;
    e2c_doy_t         doy6_reg;
    logic             pv6_reg;

    always_comb begin
        if (doe5_reg < YEAR1_BEGIN) begin
            yie6    = 2'd0;
            ybegin6 = '0;
        end else if (doe5_reg < YEAR2_BEGIN) begin
            yie6    = 2'd1;
            ybegin6 = YEAR1_BEGIN;
        end else if (doe5_reg < YEAR3_BEGIN) begin
            yie6    = 2'd2;
            ybegin6 = YEAR2_BEGIN;
        end else begin
            yie6    = 2'd3;
            ybegin6 = YEAR3_BEGIN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            sec6_reg      <= sec5_reg;
            min6_reg      <= min5_reg;
            hr6_reg       <= hr5_reg;
            year6_reg     <= {era5_reg, yie6};
            doy6_reg.leap <= yie6 == 2'd0;
            doy6_reg.doy  <= DoyW'(doe5_reg - ybegin6);
            pv6_reg       <= pv5_reg;
        end
    end

    // Stage 7: month decode into the output register.
    e2c_md_t    md7;
    logic [5:0] sec7_reg;
    logic [5:0] min7_reg;
    logic [4:0] hr7_reg;
    logic [7:0] year7_reg;
    e2c_md_t    md7_reg;
    logic       pv7_reg;

    e2c_month_decode u_month_decode (
        .doy_in (doy6_reg),
        .md_out (md7)
    );

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            sec7_reg  <= sec6_reg;
            min7_reg  <= min6_reg;
            hr7_reg   <= hr6_reg;
            year7_reg <= year6_reg;
            md7_reg   <= md7;
            pv7_reg   <= pv6_reg;
        end
    end

    assign m_tvalid = valid_reg[NStage-1];
    assign m_tdata  = {6'd0, sec7_reg, min7_reg, hr7_reg, md7_reg.day, md7_reg.month,
                       year7_reg};
    assign m_tuser  = pv7_reg;

    // An empty output stage means every stage can load.
    a_ready_when_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty output stage");

    a_fields_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (md7_reg.month >= 4'd1 && md7_reg.month <= 4'd12 &&
                      md7_reg.day >= 5'd1 && hr7_reg < 5'd24 &&
                      min7_reg < 6'd60 && sec7_reg < 6'd60))
        else $error("calendar field out of range");

    a_range_flag_year: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> year7_reg >= 8'd100)
        else $error("range flag set on a year before 2100");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[NStage-2] && m_tvalid && !m_tready |=> valid_reg[NStage-2] && m_tvalid)
        else $error("word lost in stalled pipeline");

endmodule

`default_nettype wire

// ===== verif/epoch_to_calendar_datetime_test.sv =====
// Testbench for the epoch to calendar converter: directed table plus random timestamps.
`default_nettype none

module epoch_to_calendar_datetime_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] LastInRange = 32'd3155759999;
    localparam int RandomWords = 1800;
    localparam int QuietTail   = 300;

    typedef struct packed {
        logic [7:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic       past;
    } cal_t;

    typedef struct {
        logic [31:0] epoch;
        bit          known;
        cal_t        cal;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [0:0]  m_tuser;

    cal_t      expected_dates[$];
    stim_row_t rows[$];
    int        mismatches = 0;
    int        dates_seen = 0;
    bit        gaps_on = 1'b1;
    bit        long_hold_done = 1'b0;

    epoch_to_calendar_datetime dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic cal_t make_cal(input int unsigned y, input int unsigned mo,
                                      input int unsigned d, input int unsigned h,
                                      input int unsigned mi, input int unsigned s,
                                      input bit p);
        cal_t c;
        c.year   = y[7:0];
        c.month  = mo[3:0];
        c.day    = d[4:0];
        c.hour   = h[4:0];
        c.minute = mi[5:0];
        c.second = s[5:0];
        c.past   = p;
        return c;
    endfunction

    function automatic int unsigned month_len(input int unsigned m, input bit leap);
        case (m)
            2:             return leap ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // Every fourth year is leap, 2100 included.
    function automatic cal_t to_calendar(input logic [31:0] epoch);
        int unsigned e;
        int unsigned days;
        int unsigned sod;
        int unsigned yr;
        int unsigned m;
        bit          leap;
        e    = epoch;
        days = e / 86400;
        sod  = e % 86400;
        yr   = (days / 1461) * 4;
        days = days % 1461;
        leap = 1'b1;
        while (days >= (leap ? 366 : 365)) begin
            days = days - (leap ? 366 : 365);
            yr   = yr + 1;
            leap = 1'b0;
        end
        m = 1;
        while (days >= month_len(m, leap)) begin
            days = days - month_len(m, leap);
            m    = m + 1;
        end
        return make_cal(yr, m, days + 1, sod / 3600, (sod % 3600) / 60, sod % 60,
                        epoch > LastInRange);
    endfunction

    task automatic add_row(input logic [31:0] epoch, input bit known, input cal_t cal);
        stim_row_t r;
        r.epoch = epoch;
        r.known = known;
        r.cal   = cal;
        rows.push_back(r);
    endtask

    // Offer one word, with an optional gap first; queue its date once taken.
    task automatic send_epoch(input logic [31:0] epoch, input bit known, input cal_t cal);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= epoch;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_dates.push_back(known ? cal : to_calendar(epoch));
    endtask

    // Receiver: random ready bursts, one long hold to back up the pipeline.
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!long_hold_done && dates_seen >= 400) begin
                m_tready <= 1'b0;
                repeat (150) @(posedge aclk);
                long_hold_done = 1'b1;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : check_words
        cal_t want;
        cal_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = make_cal(m_tdata[7:0], m_tdata[11:8], m_tdata[16:12], m_tdata[21:17],
                           m_tdata[27:22], m_tdata[33:28], m_tuser[0]);
            dates_seen = dates_seen + 1;
            if (expected_dates.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected word: %0d-%0d-%0d %0d:%0d:%0d past=%0b",
                             got.year, got.month, got.day, got.hour, got.minute,
                             got.second, got.past);
            end else begin
                want = expected_dates.pop_front();
                if (got.year !== want.year || got.month !== want.month ||
                    got.day !== want.day || got.hour !== want.hour ||
                    got.minute !== want.minute || got.second !== want.second ||
                    got.past !== want.past) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d-%0d-%0d %0d:%0d:%0d past=%0b, got %0d-%0d-%0d %0d:%0d:%0d past=%0b",
                                 want.year, want.month, want.day, want.hour, want.minute,
                                 want.second, want.past, got.year, got.month, got.day,
                                 got.hour, got.minute, got.second, got.past);
                end
            end
        end
    end

    initial begin
        cal_t              none;
        longint unsigned   secs;
        logic [31:0]       epoch;
        int unsigned       y;
        int unsigned       m;
        int unsigned       d;
        int unsigned       days;
        bit                lp;

        none     = '0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        add_row(32'd0,          1, make_cal(0, 1, 1, 0, 0, 0, 0));
        add_row(32'd59,         0, none);
        add_row(32'd60,         0, none);
        add_row(32'd3599,       0, none);
        add_row(32'd3600,       0, none);
        add_row(32'd86399,      0, none);
        add_row(32'd86400,      0, none);
        add_row(32'd5097599,    0, none);  // last second of Feb 28, 2000
        add_row(32'd5097600,    1, make_cal(0, 2, 29, 0, 0, 0, 0));  // leap day
        add_row(32'd31622399,   0, none);  // end of a leap year
        add_row(32'd31622400,   0, none);
        add_row(32'd36719999,   0, none);  // Feb 28 in a common year
        add_row(32'd36720000,   0, none);  // then Mar 1
        add_row(32'd94694400,   0, none);
        add_row(32'd126230399,  0, none);  // end of the first four-year era
        add_row(32'd126230400,  0, none);
        add_row(32'd131328000,  0, none);
        add_row(LastInRange,    1, make_cal(99, 12, 31, 23, 59, 59, 0));
        add_row(LastInRange + 32'd1, 1, make_cal(100, 1, 1, 0, 0, 0, 1));
        add_row(32'd3160857600, 0, none);  // Feb 29, 2100, leap by the same rule
        add_row(32'hFFFF_FFFF,  1, make_cal(136, 2, 6, 6, 28, 15, 1));
        add_row(32'h8000_0000,  0, none);
        add_row(32'h5555_5555,  0, none);
        add_row(32'hAAAA_AAAA,  0, none);

        foreach (rows[i])
            send_epoch(rows[i].epoch, rows[i].known, rows[i].cal);

        for (int i = 0; i < RandomWords; i++) begin
            if (i == RandomWords - QuietTail)
                gaps_on = 1'b0;
            if (i == 900) begin
                // drain everything before going on
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (expected_dates.size() != 0) @(posedge aclk);
            end
            case ($urandom_range(0, 9))
                0, 1, 2: epoch = $urandom;
                3, 4, 5: epoch = $urandom_range(0, LastInRange);
                6, 7, 8: begin
                    // first or last day of a random month
                    y    = $urandom_range(0, 136);
                    lp   = (y % 4) == 0;
                    m    = $urandom_range(1, 12);
                    days = (y / 4) * 1461 + (lp ? 0 : 366 + ((y % 4) - 1) * 365);
                    for (int k = 1; k < m; k++)
                        days = days + month_len(k, lp);
                    d = $urandom_range(0, 1) ? 0 : month_len(m, lp) - 1;
                    secs = longint'(days + d) * 86400;
                    case ($urandom_range(0, 2))
                        0:       secs = secs;
                        1:       secs = secs + 86399;
                        default: secs = secs + $urandom_range(0, 86399);
                    endcase
                    epoch = (secs > 64'hFFFF_FFFF) ? $urandom : secs[31:0];
                end
                default: epoch = LastInRange - 32'd100000 + $urandom_range(0, 200000);
            endcase
            send_epoch(epoch, 0, none);
        end
        s_tvalid <= 1'b0;

        while (expected_dates.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/e2c_pkg.sv
rtl/e2c_month_decode.sv
rtl/epoch_to_calendar_datetime.sv
verif/epoch_to_calendar_datetime_test.sv
